// ===== rtl/tnt_pkg.sv =====
// Shared constants and controller/datapath interface types for the triangle normal unit.
`default_nettype none
package tnt_pkg;

   localparam int KEEP_BITS  = 30;
   localparam int MUL_W      = KEEP_BITS + 1;
   localparam int SUM_W      = 2 * KEEP_BITS + 2;
   localparam int CNT_W      = 5;
   localparam int MUL_LAST   = 14;
   localparam int SQ_LAST    = 3;
   localparam int ROOT_LAST  = KEEP_BITS;
   localparam int LANE_LAST  = 2;

   typedef struct packed {
      logic       store_corner;
      logic       corner_idx;
      logic       start_tri;
      logic       mul_en;
      logic       sq_en;
      logic [3:0] step;
      logic       load_mag;
      logic       shift_en;
      logic       root_init;
      logic       root_step;
      logic       div_init;
      logic       div_step;
      logic       div_store;
      logic [1:0] lane;
      logic       set_sel;
      logic       zero_set;
      logic       publish;
   } tnt_cmd_type;

   typedef struct packed {
      logic vec_zero;
      logic det_zero;
      logic over;
   } tnt_status_type;

endpackage
`default_nettype wire

// ===== rtl/tnt_controller.sv =====
// Sequencer for corner capture, products, normalization steps and result handoff.
`default_nettype none
module tnt_controller
   import tnt_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_stall,
   input  wire logic           req_end_of_mesh,
   output logic                rsp_valid,
   input  wire logic           rsp_stall,
   input  wire tnt_status_type status,
   output tnt_cmd_type         cmd
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_MUL    = 4'd1;
   localparam logic [3:0] S_LOAD   = 4'd2;
   localparam logic [3:0] S_SHIFT  = 4'd3;
   localparam logic [3:0] S_SQ     = 4'd4;
   localparam logic [3:0] S_RINIT  = 4'd5;
   localparam logic [3:0] S_ROOT   = 4'd6;
   localparam logic [3:0] S_DINIT  = 4'd7;
   localparam logic [3:0] S_DIV    = 4'd8;
   localparam logic [3:0] S_DSTORE = 4'd9;
   localparam logic [3:0] S_FINISH = 4'd10;

   logic [3:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [1:0]       count_ff, count_in;
   logic [1:0]       lane_ff, lane_in;
   logic             sel_ff, sel_in;
   logic             valid_ff, valid_in;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = valid_ff;

   always_comb begin
      cmd            = '0;
      cmd.step       = cnt_ff[3:0];
      cmd.lane       = lane_ff;
      cmd.set_sel    = sel_ff;
      cmd.corner_idx = count_ff[0];
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      count_in       = count_ff;
      lane_in        = lane_ff;
      sel_in         = sel_ff;
      valid_in       = valid_ff && rsp_stall;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (count_ff != 2'd2) begin
                  if (req_end_of_mesh) begin
                     count_in = 2'd0;
                  end else begin
                     cmd.store_corner = 1'b1;
                     count_in         = count_ff + 2'd1;
                  end
               end else begin
                  cmd.start_tri = 1'b1;
                  count_in      = 2'd0;
                  cnt_in        = '0;
                  state_in      = S_MUL;
               end
            end
         end
         S_MUL: begin
            cmd.mul_en = 1'b1;
            if (cnt_ff == CNT_W'(MUL_LAST)) begin
               sel_in   = 1'b0;
               state_in = S_LOAD;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_LOAD: begin
            if ((sel_ff && status.det_zero) || status.vec_zero) begin
               cmd.zero_set = 1'b1;
               if (sel_ff) begin
                  state_in = S_FINISH;
               end else begin
                  sel_in = 1'b1;
               end
            end else begin
               cmd.load_mag = 1'b1;
               state_in     = S_SHIFT;
            end
         end
         S_SHIFT: begin
            if (status.over) begin
               cmd.shift_en = 1'b1;
            end else begin
               cnt_in   = '0;
               state_in = S_SQ;
            end
         end
         S_SQ: begin
            cmd.sq_en = 1'b1;
            if (cnt_ff == CNT_W'(SQ_LAST)) begin
               state_in = S_RINIT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_RINIT: begin
            cmd.root_init = 1'b1;
            cnt_in        = '0;
            state_in      = S_ROOT;
         end
         S_ROOT: begin
            cmd.root_step = 1'b1;
            if (cnt_ff == CNT_W'(ROOT_LAST)) begin
               lane_in  = 2'd0;
               state_in = S_DINIT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_DINIT: begin
            cmd.div_init = 1'b1;
            cnt_in       = '0;
            state_in     = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == CNT_W'(FRAC_BITS)) begin
               state_in = S_DSTORE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_DSTORE: begin
            cmd.div_store = 1'b1;
            if (lane_ff == 2'(LANE_LAST)) begin
               if (sel_ff) begin
                  state_in = S_FINISH;
               end else begin
                  sel_in   = 1'b1;
                  state_in = S_LOAD;
               end
            end else begin
               lane_in  = lane_ff + 2'd1;
               state_in = S_DINIT;
            end
         end
         S_FINISH: begin
            if (!valid_ff || !rsp_stall) begin
               cmd.publish = 1'b1;
               valid_in    = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         count_ff <= 2'd0;
         lane_ff  <= 2'd0;
         sel_ff   <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         count_ff <= count_in;
         lane_ff  <= lane_in;
         sel_ff   <= sel_in;
         valid_ff <= valid_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/tnt_datapath.sv =====
// Corner storage, shared multiplier, square root and divider for the triangle normal unit.
`default_nettype none
module tnt_datapath
   import tnt_pkg::*;
#(
   parameter int COORD_WIDTH = 24,
   parameter int FRAC_BITS   = 16
) (
   input  wire logic                          clock,
   input  wire tnt_cmd_type                   cmd,
   output tnt_status_type                     status,
   input  wire logic [COORD_WIDTH-1:0]        req_pos_x,
   input  wire logic [COORD_WIDTH-1:0]        req_pos_y,
   input  wire logic [COORD_WIDTH-1:0]        req_pos_z,
   input  wire logic [COORD_WIDTH-1:0]        req_tex_u,
   input  wire logic [COORD_WIDTH-1:0]        req_tex_v,
   input  wire logic                          req_end_of_mesh,
   output logic signed [FRAC_BITS+1:0]        rsp_normal_x,
   output logic signed [FRAC_BITS+1:0]        rsp_normal_y,
   output logic signed [FRAC_BITS+1:0]        rsp_normal_z,
   output logic signed [FRAC_BITS+1:0]        rsp_tangent_x,
   output logic signed [FRAC_BITS+1:0]        rsp_tangent_y,
   output logic signed [FRAC_BITS+1:0]        rsp_tangent_z,
   output logic                               rsp_flat_triangle,
   output logic                               rsp_flat_mapping,
   output logic                               rsp_final_triangle
);

   localparam int CW     = COORD_WIDTH;
   localparam int DSHIFT = (CW > 29) ? CW - 29 : 0;
   localparam int DW     = CW - DSHIFT + 1;
   localparam int VW     = 2 * DW + 1;
   localparam int AW     = (VW > KEEP_BITS) ? VW : KEEP_BITS + 1;
   localparam int OW     = FRAC_BITS + 2;
   localparam int Q      = FRAC_BITS + 1;
   localparam int RW     = KEEP_BITS + 1;
   localparam int NW     = KEEP_BITS + FRAC_BITS + 1;
   localparam int PW     = 2 * MUL_W;

   function automatic logic signed [DW-1:0] delta_f(input logic [CW-1:0] a,
                                                    input logic [CW-1:0] b);
      logic [CW:0] d;
      logic [CW:0] m;
      logic [CW:0] ms;
      d  = {a[CW-1], a} - {b[CW-1], b};
      m  = d[CW] ? (~d + 1'b1) : d;
      ms = m >> DSHIFT;
      delta_f = d[CW] ? $signed(DW'(~ms + 1'b1)) : $signed(DW'(ms));
   endfunction

   logic [CW-1:0] c_px_ff [2];
   logic [CW-1:0] c_py_ff [2];
   logic [CW-1:0] c_pz_ff [2];
   logic [CW-1:0] c_tu_ff [2];
   logic [CW-1:0] c_tv_ff [2];

   logic signed [DW-1:0] e1_ff [3];
   logic signed [DW-1:0] e2_ff [3];
   logic signed [DW-1:0] du1_ff, dv1_ff, du2_ff, dv2_ff;
   logic                 eom_ff;

   logic signed [MUL_W-1:0] op_a, op_b;
   logic signed [PW-1:0]    p_ff;
   logic signed [PW-1:0]    acc_ff;
   logic signed [PW-1:0]    diff;
   logic [3:0]              j_idx;

   logic signed [VW-1:0] n_ff [3];
   logic signed [VW-1:0] t_ff [3];
   logic signed [VW-1:0] det_ff;
   logic signed [VW-1:0] v_sel [3];
   logic [2:0]           v_sign;

   logic [AW-1:0]        a_ff [3];
   logic [1:0]           a_idx;
   logic [AW-1:0]        a_pick;

   logic [SUM_W-1:0]     sum_ff;
   logic [SUM_W-1:0]     x_ff, root_ff, bit_ff;
   logic [SUM_W-1:0]     trial_root;
   logic [RW-1:0]        r;

   logic [NW-1:0]        num;
   logic [RW-1:0]        rem_ff;
   logic [Q-1:0]         low_ff, q_ff;
   logic [RW:0]          trial;
   logic [OW-1:0]        qx, qs;
   logic                 neg;

   logic signed [OW-1:0] rn_ff [3];
   logic signed [OW-1:0] rt_ff [3];
   logic                 fn_ff, ft_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         v_sel[i]  = cmd.set_sel ? t_ff[i] : n_ff[i];
         v_sign[i] = v_sel[i][VW-1];
      end
   end

   assign status.vec_zero = (v_sel[0] == '0) && (v_sel[1] == '0) && (v_sel[2] == '0);
   assign status.det_zero = (det_ff == '0);
   assign status.over     = (|a_ff[0][AW-1:KEEP_BITS]) || (|a_ff[1][AW-1:KEEP_BITS])
                            || (|a_ff[2][AW-1:KEEP_BITS]);

   assign a_idx = cmd.sq_en ? cmd.step[1:0] : cmd.lane;

   always_comb begin
      case (a_idx)
         2'd0:    a_pick = a_ff[0];
         2'd1:    a_pick = a_ff[1];
         2'd2:    a_pick = a_ff[2];
         default: a_pick = '0;
      endcase
   end

   always_comb begin
      op_a = '0;
      op_b = '0;
      if (cmd.sq_en) begin
         op_a = $signed({1'b0, a_pick[KEEP_BITS-1:0]});
         op_b = $signed({1'b0, a_pick[KEEP_BITS-1:0]});
      end else begin
         case (cmd.step)
            4'd0:  begin op_a = MUL_W'(e1_ff[1]); op_b = MUL_W'(e2_ff[2]); end
            4'd1:  begin op_a = MUL_W'(e1_ff[2]); op_b = MUL_W'(e2_ff[1]); end
            4'd2:  begin op_a = MUL_W'(e1_ff[2]); op_b = MUL_W'(e2_ff[0]); end
            4'd3:  begin op_a = MUL_W'(e1_ff[0]); op_b = MUL_W'(e2_ff[2]); end
            4'd4:  begin op_a = MUL_W'(e1_ff[0]); op_b = MUL_W'(e2_ff[1]); end
            4'd5:  begin op_a = MUL_W'(e1_ff[1]); op_b = MUL_W'(e2_ff[0]); end
            4'd6:  begin op_a = MUL_W'(dv2_ff);   op_b = MUL_W'(e1_ff[0]); end
            4'd7:  begin op_a = MUL_W'(dv1_ff);   op_b = MUL_W'(e2_ff[0]); end
            4'd8:  begin op_a = MUL_W'(dv2_ff);   op_b = MUL_W'(e1_ff[1]); end
            4'd9:  begin op_a = MUL_W'(dv1_ff);   op_b = MUL_W'(e2_ff[1]); end
            4'd10: begin op_a = MUL_W'(dv2_ff);   op_b = MUL_W'(e1_ff[2]); end
            4'd11: begin op_a = MUL_W'(dv1_ff);   op_b = MUL_W'(e2_ff[2]); end
            4'd12: begin op_a = MUL_W'(du1_ff);   op_b = MUL_W'(dv2_ff);   end
            4'd13: begin op_a = MUL_W'(du2_ff);   op_b = MUL_W'(dv1_ff);   end
            default: begin op_a = '0; op_b = '0; end
         endcase
      end
   end

   assign diff  = acc_ff - p_ff;
   assign j_idx = cmd.step - 4'd1;

   assign trial_root = root_ff + bit_ff;
   assign r          = root_ff[RW-1:0];
   assign num        = (NW'(a_pick[KEEP_BITS-1:0]) << FRAC_BITS) + NW'(r >> 1);
   assign trial      = {rem_ff, low_ff[Q-1]};
   assign qx         = {1'b0, q_ff};
   assign neg        = v_sign[cmd.lane] ^ (cmd.set_sel & det_ff[VW-1]);
   assign qs         = neg ? (~qx + 1'b1) : qx;

   always_ff @(posedge clock) begin
      if (cmd.store_corner) begin
         c_px_ff[cmd.corner_idx] <= req_pos_x;
         c_py_ff[cmd.corner_idx] <= req_pos_y;
         c_pz_ff[cmd.corner_idx] <= req_pos_z;
         c_tu_ff[cmd.corner_idx] <= req_tex_u;
         c_tv_ff[cmd.corner_idx] <= req_tex_v;
      end
      if (cmd.start_tri) begin
         e1_ff[0] <= delta_f(c_px_ff[1], c_px_ff[0]);
         e1_ff[1] <= delta_f(c_py_ff[1], c_py_ff[0]);
         e1_ff[2] <= delta_f(c_pz_ff[1], c_pz_ff[0]);
         e2_ff[0] <= delta_f(req_pos_x, c_px_ff[0]);
         e2_ff[1] <= delta_f(req_pos_y, c_py_ff[0]);
         e2_ff[2] <= delta_f(req_pos_z, c_pz_ff[0]);
         du1_ff   <= delta_f(c_tu_ff[1], c_tu_ff[0]);
         dv1_ff   <= delta_f(c_tv_ff[1], c_tv_ff[0]);
         du2_ff   <= delta_f(req_tex_u, c_tu_ff[0]);
         dv2_ff   <= delta_f(req_tex_v, c_tv_ff[0]);
         eom_ff   <= req_end_of_mesh;
      end
      if (cmd.mul_en || cmd.sq_en) begin
         p_ff <= op_a * op_b;
      end
      if (cmd.mul_en && cmd.step != 4'd0) begin
         if (!j_idx[0]) begin
            acc_ff <= p_ff;
         end else begin
            case (j_idx[3:1])
               3'd0:    n_ff[0] <= VW'(diff);
               3'd1:    n_ff[1] <= VW'(diff);
               3'd2:    n_ff[2] <= VW'(diff);
               3'd3:    t_ff[0] <= VW'(diff);
               3'd4:    t_ff[1] <= VW'(diff);
               3'd5:    t_ff[2] <= VW'(diff);
               default: det_ff  <= VW'(diff);
            endcase
         end
      end
      if (cmd.load_mag) begin
         for (int i = 0; i < 3; i++) begin
            a_ff[i] <= AW'(v_sign[i] ? (~v_sel[i] + 1'b1) : v_sel[i]);
         end
      end else if (cmd.shift_en) begin
         for (int i = 0; i < 3; i++) begin
            a_ff[i] <= a_ff[i] >> 1;
         end
      end
      if (cmd.sq_en && cmd.step != 4'd0) begin
         sum_ff <= ((cmd.step == 4'd1) ? '0 : sum_ff) + p_ff[SUM_W-1:0];
      end
      if (cmd.root_init) begin
         x_ff    <= sum_ff;
         root_ff <= '0;
         bit_ff  <= SUM_W'(1) << (SUM_W - 2);
      end else if (cmd.root_step) begin
         if (x_ff >= trial_root) begin
            x_ff    <= x_ff - trial_root;
            root_ff <= (root_ff >> 1) + bit_ff;
         end else begin
            root_ff <= root_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
      if (cmd.div_init) begin
         rem_ff <= RW'(num[NW-1:Q]);
         low_ff <= num[Q-1:0];
         q_ff   <= '0;
      end else if (cmd.div_step) begin
         if (trial >= {1'b0, r}) begin
            rem_ff <= RW'(trial - {1'b0, r});
            q_ff   <= {q_ff[Q-2:0], 1'b1};
         end else begin
            rem_ff <= trial[RW-1:0];
            q_ff   <= {q_ff[Q-2:0], 1'b0};
         end
         low_ff <= low_ff << 1;
      end
      if (cmd.zero_set) begin
         if (cmd.set_sel) begin
            rt_ff[0] <= '0;
            rt_ff[1] <= '0;
            rt_ff[2] <= '0;
            ft_ff    <= 1'b1;
         end else begin
            rn_ff[0] <= '0;
            rn_ff[1] <= '0;
            rn_ff[2] <= '0;
            fn_ff    <= 1'b1;
         end
      end else if (cmd.div_store) begin
         if (cmd.set_sel) begin
            rt_ff[cmd.lane] <= $signed(qs);
            ft_ff           <= 1'b0;
         end else begin
            rn_ff[cmd.lane] <= $signed(qs);
            fn_ff           <= 1'b0;
         end
      end
      if (cmd.publish) begin
         rsp_normal_x       <= rn_ff[0];
         rsp_normal_y       <= rn_ff[1];
         rsp_normal_z       <= rn_ff[2];
         rsp_tangent_x      <= rt_ff[0];
         rsp_tangent_y      <= rt_ff[1];
         rsp_tangent_z      <= rt_ff[2];
         rsp_flat_triangle  <= fn_ff;
         rsp_flat_mapping   <= ft_ff;
         rsp_final_triangle <= eom_ff;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/triangle_normal_tangent_unit.sv =====
// Top level of the triangle face normal and tangent unit.
//
//   channel  direction  handshake            word
//   req      in         req_valid/req_stall  one vertex: position, texcoord, end_of_mesh
//   rsp      out        rsp_valid/rsp_stall  one triangle: unit normal, unit tangent, flags
//
// The first two vertices of a triangle are stored as they arrive. The third starts a
// computation in which each vector is shifted right until it fits in 30 bits, and
// one shared multiplier, a bit-pair square root and a restoring divider do the
// work. req_stall is high during that work. A finished word waits in the output
// register while the next vertices are taken.
// Reset is synchronous and clears the corner count and the output valid.
`default_nettype none
module triangle_normal_tangent_unit
   import tnt_pkg::*;
#(
   parameter int COORD_WIDTH = 24,
   parameter int FRAC_BITS   = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [COORD_WIDTH-1:0] req_pos_x,
   input  wire logic [COORD_WIDTH-1:0] req_pos_y,
   input  wire logic [COORD_WIDTH-1:0] req_pos_z,
   input  wire logic [COORD_WIDTH-1:0] req_tex_u,
   input  wire logic [COORD_WIDTH-1:0] req_tex_v,
   input  wire logic                   req_end_of_mesh,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic signed [FRAC_BITS+1:0] rsp_normal_x,
   output logic signed [FRAC_BITS+1:0] rsp_normal_y,
   output logic signed [FRAC_BITS+1:0] rsp_normal_z,
   output logic signed [FRAC_BITS+1:0] rsp_tangent_x,
   output logic signed [FRAC_BITS+1:0] rsp_tangent_y,
   output logic signed [FRAC_BITS+1:0] rsp_tangent_z,
   output logic                        rsp_flat_triangle,
   output logic                        rsp_flat_mapping,
   output logic                        rsp_final_triangle
);

   tnt_cmd_type    cmd;
   tnt_status_type status;

   tnt_controller #(
      .FRAC_BITS (FRAC_BITS)
   ) u_controller (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_end_of_mesh (req_end_of_mesh),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .status          (status),
      .cmd             (cmd)
   );

   tnt_datapath #(
      .COORD_WIDTH (COORD_WIDTH),
      .FRAC_BITS   (FRAC_BITS)
   ) u_datapath (
      .clock              (clock),
      .cmd                (cmd),
      .status             (status),
      .req_pos_x          (req_pos_x),
      .req_pos_y          (req_pos_y),
      .req_pos_z          (req_pos_z),
      .req_tex_u          (req_tex_u),
      .req_tex_v          (req_tex_v),
      .req_end_of_mesh    (req_end_of_mesh),
      .rsp_normal_x       (rsp_normal_x),
      .rsp_normal_y       (rsp_normal_y),
      .rsp_normal_z       (rsp_normal_z),
      .rsp_tangent_x      (rsp_tangent_x),
      .rsp_tangent_y      (rsp_tangent_y),
      .rsp_tangent_z      (rsp_tangent_z),
      .rsp_flat_triangle  (rsp_flat_triangle),
      .rsp_flat_mapping   (rsp_flat_mapping),
      .rsp_final_triangle (rsp_final_triangle)
   );

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
// Testbench for the triangle face normal and tangent unit: vertex stream in, checked triangles out.
`default_nettype none
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CW = 24;
   localparam int FB = 16;
   localparam int OW = FB + 2;

   typedef struct packed {
      logic [CW-1:0] px, py, pz, tu, tv;
      logic          eom;
   } vertex_type;

   typedef struct packed {
      logic [OW-1:0] nx, ny, nz, tx, ty, tz;
      logic          flat_tri, flat_map, last_tri;
   } face_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [CW-1:0] req_pos_x = '0, req_pos_y = '0, req_pos_z = '0;
   logic [CW-1:0] req_tex_u = '0, req_tex_v = '0;
   logic req_end_of_mesh = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic signed [OW-1:0] rsp_normal_x, rsp_normal_y, rsp_normal_z;
   logic signed [OW-1:0] rsp_tangent_x, rsp_tangent_y, rsp_tangent_z;
   logic rsp_flat_triangle, rsp_flat_mapping, rsp_final_triangle;

   triangle_normal_tangent_unit u_top (.*);

   vertex_type pending_vertices[$];
   face_type   expected_faces[$];
   int      mismatches = 0;
   int      faces_seen = 0;
   int      vertices_sent = 0;
   bit      quiet = 0;
   bit      hold_rsp = 0;
   bit      pause_req = 0;
   bit      stim_done = 0;

   int         corners = 0;
   vertex_type held[2];

   initial forever #1 clock = ~clock;

   function automatic longint sx(logic [CW-1:0] v);
      return longint'(signed'(v));
   endfunction

   function automatic void queue_vertex(vertex_type v);
      pending_vertices = {pending_vertices, v};
   endfunction

   function automatic void unit_vec(input longint v[3], input bit flip,
                                    output logic [OW-1:0] o[3], output bit zero);
      longint unsigned a[3], m, sum, r, rem, bitv, q;
      int len, k;
      m = 0;
      for (int i = 0; i < 3; i++) begin
         a[i] = v[i] < 0 ? -v[i] : v[i];
         if (a[i] > m) m = a[i];
      end
      zero = (m == 0);
      for (int i = 0; i < 3; i++) o[i] = '0;
      if (zero) return;
      len = 0;
      while (len < 64 && (m >> len) != 0) len++;
      k = len > 30 ? len - 30 : 0;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
         a[i] = a[i] >> k;
         sum += a[i] * a[i];
      end
      r = 0;
      rem = sum;
      bitv = 64'd1 << 62;
      while (bitv > rem) bitv >>= 2;
      while (bitv != 0) begin
         if (rem >= r + bitv) begin
            rem -= r + bitv;
            r = (r >> 1) + bitv;
         end else begin
            r >>= 1;
         end
         bitv >>= 2;
      end
      for (int i = 0; i < 3; i++) begin
         q = ((a[i] << FB) + (r >> 1)) / r;
         o[i] = ((v[i] < 0) != flip) ? OW'(-q) : OW'(q);
      end
   endfunction

   function automatic void predict_face(vertex_type c);
      longint e1[3], e2[3], n[3], t[3], du1, dv1, du2, dv2, det;
      logic [OW-1:0] o[3];
      bit z;
      face_type f;
      if (corners < 2) begin
         if (c.eom) begin
            corners = 0;
         end else begin
            held[corners] = c;
            corners++;
         end
         return;
      end
      e1[0] = sx(held[1].px) - sx(held[0].px);
      e1[1] = sx(held[1].py) - sx(held[0].py);
      e1[2] = sx(held[1].pz) - sx(held[0].pz);
      e2[0] = sx(c.px) - sx(held[0].px);
      e2[1] = sx(c.py) - sx(held[0].py);
      e2[2] = sx(c.pz) - sx(held[0].pz);
      du1 = sx(held[1].tu) - sx(held[0].tu);
      dv1 = sx(held[1].tv) - sx(held[0].tv);
      du2 = sx(c.tu) - sx(held[0].tu);
      dv2 = sx(c.tv) - sx(held[0].tv);
      n[0] = e1[1] * e2[2] - e1[2] * e2[1];
      n[1] = e1[2] * e2[0] - e1[0] * e2[2];
      n[2] = e1[0] * e2[1] - e1[1] * e2[0];
      for (int i = 0; i < 3; i++) t[i] = dv2 * e1[i] - dv1 * e2[i];
      det = du1 * dv2 - du2 * dv1;
      unit_vec(n, 0, o, z);
      f.nx = o[0]; f.ny = o[1]; f.nz = o[2]; f.flat_tri = z;
      if (det == 0) begin
         f.tx = '0; f.ty = '0; f.tz = '0; f.flat_map = 1;
      end else begin
         unit_vec(t, det < 0, o, z);
         f.tx = o[0]; f.ty = o[1]; f.tz = o[2]; f.flat_map = z;
      end
      f.last_tri = c.eom;
      expected_faces = {expected_faces, f};
      corners = 0;
   endfunction

   function automatic logic [CW-1:0] rand_coord(int mode);
      case (mode)
         0: return CW'($urandom);
         1: return CW'($urandom_range(0, 2000) - 1000);
         2: return 24'h7FFFFF;
         default: return 24'h800000;
      endcase
   endfunction

   function automatic vertex_type rand_vertex(bit eom);
      vertex_type v;
      int mode;
      mode = $urandom_range(0, 9) < 6 ? 0 :
             ($urandom_range(0, 9) < 8 ? 1 : $urandom_range(2, 3));
      v.px = rand_coord(mode); v.py = rand_coord(mode); v.pz = rand_coord(mode);
      v.tu = rand_coord(mode); v.tv = rand_coord(mode);
      v.eom = eom;
      return v;
   endfunction

   function automatic vertex_type mk(int x, int y, int z, int u, int v, bit eom);
      vertex_type r;
      r.px = CW'(x); r.py = CW'(y); r.pz = CW'(z);
      r.tu = CW'(u); r.tv = CW'(v); r.eom = eom;
      return r;
   endfunction

   initial begin
      int one;
      one = 1 << FB;
      // Plain unit triangle, then a degenerate one with collinear corners and flat mapping.
      queue_vertex(mk(0, 0, 0, 0, 0, 0));
      queue_vertex(mk(one, 0, 0, one, 0, 0));
      queue_vertex(mk(0, one, 0, 0, one, 0));
      queue_vertex(mk(0, 0, 0, 0, 0, 0));
      queue_vertex(mk(one, one, one, one, one, 0));
      queue_vertex(mk(2 * one, 2 * one, 2 * one, 2 * one, 2 * one, 1));
      // Mirrored mapping gives a negative determinant.
      queue_vertex(mk(0, 0, 0, 0, 0, 0));
      queue_vertex(mk(one, 0, 0, 0, one, 0));
      queue_vertex(mk(0, one, 0, one, 0, 0));
      // End of mesh on the first and on the second corner.
      queue_vertex(mk(5, 6, 7, 8, 9, 1));
      queue_vertex(mk(5, 6, 7, 8, 9, 0));
      queue_vertex(mk(1, 2, 3, 4, 5, 1));
      // Extremes of every field.
      queue_vertex(mk(-8388608, 8388607, -8388608, 8388607, -8388608, 0));
      queue_vertex(mk(8388607, -8388608, 8388607, -8388608, 8388607, 0));
      queue_vertex(mk(-8388608, -8388608, 8388607, 8388607, 8388607, 1));
      queue_vertex(mk(8388607, 8388607, 8388607, -8388608, -8388608, 0));
      queue_vertex(mk(-8388608, 8388607, -8388608, 8388607, 8388607, 0));
      queue_vertex(mk(8388607, -8388608, -8388608, -8388608, 8388607, 0));
      for (int i = 0; i < 137; i++) begin
         if ($urandom_range(0, 9) == 0) begin
            queue_vertex(rand_vertex($urandom_range(0, 1)));
         end else begin
            queue_vertex(rand_vertex(0));
            queue_vertex(rand_vertex(0));
            queue_vertex(rand_vertex($urandom_range(0, 5) == 0));
         end
      end
   end

   // Quiet stretch, a long receiver hold-off, and one pause until the pipeline drains.
   initial begin
      repeat (4) @(posedge clock);
      reset <= 0;
      repeat (300) @(posedge clock);
      quiet <= 1;
      repeat (1500) @(posedge clock);
      quiet <= 0;
      hold_rsp <= 1;
      repeat (400) @(posedge clock);
      hold_rsp <= 0;
      pause_req <= 1;
      wait (expected_faces.size() == 0 && !rsp_valid);
      @(posedge clock);
      pause_req <= 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 0;
      end else if (!(req_valid && req_stall)) begin
         if (pending_vertices.size() != 0 && !pause_req &&
             (quiet || $urandom_range(0, 99) >= 11)) begin
            vertex_type v;
            v = pending_vertices.pop_front();
            req_valid <= 1;
            req_pos_x <= v.px; req_pos_y <= v.py; req_pos_z <= v.pz;
            req_tex_u <= v.tu; req_tex_v <= v.tv; req_end_of_mesh <= v.eom;
         end else begin
            req_valid <= 0;
            if (pending_vertices.size() == 0) stim_done <= 1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 0;
      end else begin
         rsp_stall <= hold_rsp || (!quiet && $urandom_range(0, 99) < 11);
         if (req_valid && !req_stall) begin
            vertices_sent++;
            predict_face({req_pos_x, req_pos_y, req_pos_z, req_tex_u, req_tex_v,
                          req_end_of_mesh});
         end
         if (rsp_valid && !rsp_stall) begin
            face_type got;
            face_type want;
            got = {rsp_normal_x, rsp_normal_y, rsp_normal_z, rsp_tangent_x, rsp_tangent_y,
                   rsp_tangent_z, rsp_flat_triangle, rsp_flat_mapping, rsp_final_triangle};
            faces_seen++;
            if (expected_faces.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected word %h", got);
            end else begin
               want = expected_faces.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch on triangle %0d: expected %h got %h",
                              faces_seen, want, got);
               end
            end
         end
      end
   end

   initial begin
      wait (stim_done && !req_valid && expected_faces.size() == 0);
      repeat (300) @(posedge clock);
      $display("Sent %0d vertices, checked %0d triangles, %0d mismatches.",
               vertices_sent, faces_seen, mismatches);
      if (mismatches == 0 && expected_faces.size() == 0 && !rsp_valid)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

   initial begin
      #400000;
      $display("tb_top: done, errors");
      $finish;
   end
endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/tnt_pkg.sv
rtl/tnt_controller.sv
rtl/tnt_datapath.sv
rtl/triangle_normal_tangent_unit.sv
verif/tb_top.sv
